/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* rtl/dsm_pkg.sv */
package dsm_pkg;

  localparam int DefMaxElements = 1024;

  localparam int IdxW = 10;
  localparam int TotW = 20;
  localparam int MemW = 11;
  localparam int SumW = 19;
  localparam int CntW = 10;

  localparam logic [1:0] CmdMove  = 2'd0;
  localparam logic [1:0] CmdMerge = 2'd1;
  localparam logic [1:0] CmdSame  = 2'd2;
  localparam logic [1:0] CmdQuery = 2'd3;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StSame  = 2'd1;
  localparam logic [1:0] StRange = 2'd2;

  typedef struct packed {
    logic [TotW-1:0] x;
    logic [TotW-1:0] y;
    logic            sub;
  } alu_req_t;

endpackage

/* rtl/dsm_ram.sv */
module dsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dsm_alu.sv */
module dsm_alu (
  input  dsm_pkg::alu_req_t          req_i,
  output logic [dsm_pkg::TotW-1:0]   res_o
);

  // shared add/subtract for group sums and sizes
  assign res_o = req_i.sub ? (req_i.x - req_i.y) : (req_i.x + req_i.y);

endmodule

/* rtl/disjoint_set_with_move_core.sv */
// channel   dir  signals                         word
// s_axis    in   tvalid tready tdata[23:0]       one command
// m_axis    out  tvalid tready tdata[47:0]       one result
// cfg       in   cfg_we_i cfg_wdata_i[9:0]       element_count
//
// after reset a clearing pass writes every store entry; no command is taken until it ends
// a find reads the element, reads one parent per group link plus the root check, and
//   writes the compressed pointer; an out-of-range index ends it at the element read
// move/merge: accept, two finds, record reads and writes through the shared adder, then
//   output; same-set: two finds, then output; query: one find, record read, then output
// a result waits in the output register; a later command stalls at its output until then
module disjoint_set_with_move_core #(
  parameter int MAX_ELEMENTS = dsm_pkg::DefMaxElements
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cmd[1:0] elem_a[11:2] elem_b[21:12] zero[23:22]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status[1:0] same_set[2] group_size[13:3]
                                     // group_sum[32:14] group_count[42:33] zero[47:43]
);

  localparam int AW   = $clog2(MAX_ELEMENTS);
  localparam int IdxW = dsm_pkg::IdxW;
  localparam int TotW = dsm_pkg::TotW;
  localparam int MemW = dsm_pkg::MemW;
  localparam int SumW = dsm_pkg::SumW;
  localparam int CntW = dsm_pkg::CntW;

  // sequencer states
  typedef enum logic [14:0] {
    S_CLR   = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_E_RD  = 15'b000000000000100,
    S_E_CAP = 15'b000000000001000,
    S_P_RD  = 15'b000000000010000,
    S_P_CAP = 15'b000000000100000,
    S_E_WR  = 15'b000000001000000,
    S_A_RD  = 15'b000000010000000,
    S_B_RD  = 15'b000000100000000,
    S_B_CAP = 15'b000001000000000,
    S_WA_T  = 15'b000010000000000,
    S_WA_M  = 15'b000100000000000,
    S_WB_T  = 15'b001000000000000,
    S_WB_M  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]   clr_q, clr_d;
  logic [1:0]      cmd_q, cmd_d;
  logic [IdxW-1:0] a_q, a_d, b_q, b_d;
  logic            side_q, side_d;
  logic [AW-1:0]   g_q, g_d, ga_q, ga_d, gb_q, gb_d;
  logic [AW:0]     steps_q, steps_d;
  logic            none_a_q, none_a_d, none_b_q, none_b_d;
  logic [TotW-1:0] ta_q, ta_d, tb_q, tb_d;
  logic [MemW-1:0] ma_q, ma_d, mb_q, mb_d;
  logic [1:0]      res_st_q, res_st_d;
  logic            res_same_q, res_same_d;
  logic [CntW-1:0] count_q, count_d, merge_q, merge_d;

  logic            ovalid_q, ovalid_d;
  logic [1:0]      ost_q, ost_d;
  logic            osame_q, osame_d;
  logic [MemW-1:0] osize_q, osize_d;
  logic [SumW-1:0] osum_q, osum_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;

  // memory ports
  logic            eg_we, gp_we, tot_we, mem_we;
  logic [AW-1:0]   eg_addr, gp_addr, tot_addr, mem_addr;
  logic [AW-1:0]   eg_wdata, gp_wdata, eg_rdata, gp_rdata;
  logic [TotW-1:0] tot_wdata, tot_rdata;
  logic [MemW-1:0] mem_wdata, mem_rdata;

  dsm_pkg::alu_req_t alu_req;
  logic [TotW-1:0]   alu_res;

  // element being resolved and its store address
  logic [IdxW-1:0]    elem;
  logic [AW+IdxW-1:0] elem_ext, a_ext;
  logic [AW-1:0]      elem_addr, a_addr;
  logic               elem_ok;
  logic               is_move, is_merge, big_a;
  logic               root_done, root_none;
  logic               na, nb;
  logic [AW-1:0]      rga, rgb;

  assign elem      = side_q ? b_q : a_q;
  assign elem_ext  = {{AW{1'b0}}, elem};
  assign elem_addr = elem_ext[AW-1:0];
  assign a_ext     = {{AW{1'b0}}, a_q};
  assign a_addr    = a_ext[AW-1:0];
  assign elem_ok   = (elem <= count_q) && (32'(elem) < MAX_ELEMENTS);
  assign is_move   = (cmd_q == dsm_pkg::CmdMove);
  assign is_merge  = (cmd_q == dsm_pkg::CmdMerge);
  assign big_a     = (ma_q > mb_q);

  dsm_ram #(.Width(AW), .Depth(MAX_ELEMENTS)) u_elem_group (
    .clk_i, .we_i(eg_we), .addr_i(eg_addr), .wdata_i(eg_wdata), .rdata_o(eg_rdata)
  );
  dsm_ram #(.Width(AW), .Depth(MAX_ELEMENTS)) u_group_parent (
    .clk_i, .we_i(gp_we), .addr_i(gp_addr), .wdata_i(gp_wdata), .rdata_o(gp_rdata)
  );
  dsm_ram #(.Width(TotW), .Depth(MAX_ELEMENTS)) u_group_total (
    .clk_i, .we_i(tot_we), .addr_i(tot_addr), .wdata_i(tot_wdata), .rdata_o(tot_rdata)
  );
  dsm_ram #(.Width(MemW), .Depth(MAX_ELEMENTS)) u_group_members (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );

  dsm_alu u_alu (.req_i(alu_req), .res_o(alu_res));

  // alu operands per write state
  always_comb begin
    alu_req = '0;
    case (state_q)
      S_WA_T: begin
        alu_req.x   = ta_q;
        alu_req.y   = is_move ? {{(TotW-IdxW){1'b0}}, a_q} : tb_q;
        alu_req.sub = is_move;
      end
      S_WA_M: begin
        alu_req.x   = {{(TotW-MemW){1'b0}}, ma_q};
        alu_req.y   = is_move ? TotW'(1) : {{(TotW-MemW){1'b0}}, mb_q};
        alu_req.sub = is_move;
      end
      S_WB_T: begin
        alu_req.x = tb_q;
        alu_req.y = is_move ? {{(TotW-IdxW){1'b0}}, a_q} : ta_q;
      end
      S_WB_M: begin
        alu_req.x = {{(TotW-MemW){1'b0}}, mb_q};
        alu_req.y = is_move ? TotW'(1) : {{(TotW-MemW){1'b0}}, ma_q};
      end
      default: alu_req = '0;
    endcase
  end

  // memory port steering
  always_comb begin
    eg_we = 1'b0;  eg_addr = elem_addr;  eg_wdata = g_q;
    gp_we = 1'b0;  gp_addr = g_q;        gp_wdata = gb_q;
    tot_we = 1'b0; tot_addr = ga_q;      tot_wdata = alu_res;
    mem_we = 1'b0; mem_addr = ga_q;      mem_wdata = alu_res[MemW-1:0];
    case (state_q)
      S_CLR: begin
        eg_we = 1'b1;  eg_addr = clr_q;  eg_wdata = clr_q;
        gp_we = 1'b1;  gp_addr = clr_q;  gp_wdata = clr_q;
        tot_we = 1'b1; tot_addr = clr_q; tot_wdata = {{(TotW-AW){1'b0}}, clr_q};
        mem_we = 1'b1; mem_addr = clr_q; mem_wdata = MemW'(1);
      end
      S_E_WR: eg_we = 1'b1;
      S_B_RD: begin
        tot_addr = gb_q;
        mem_addr = gb_q;
      end
      S_WA_T: begin
        tot_we = 1'b1;
        if (is_merge && !big_a) tot_wdata = '0;
        // moved element points at the destination root
        eg_we    = is_move;
        eg_addr  = a_addr;
        eg_wdata = gb_q;
        // root a goes under b when its group is not larger (a tie included)
        gp_we    = is_merge && !big_a;
        gp_addr  = ga_q;
        gp_wdata = gb_q;
      end
      S_WA_M: begin
        mem_we = 1'b1;
        if (is_merge && !big_a) mem_wdata = '0;
      end
      S_WB_T: begin
        tot_we = 1'b1;
        tot_addr = gb_q;
        if (is_merge && big_a) tot_wdata = '0;
        gp_we    = is_merge && big_a;
        gp_addr  = gb_q;
        gp_wdata = ga_q;
      end
      S_WB_M: begin
        mem_we = 1'b1;
        mem_addr = gb_q;
        if (is_merge && big_a) mem_wdata = '0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;  clr_d = clr_q;    cmd_d = cmd_q;
    a_d = a_q;  b_d = b_q;  side_d = side_q;
    g_d = g_q;  ga_d = ga_q;  gb_d = gb_q;  steps_d = steps_q;
    none_a_d = none_a_q;  none_b_d = none_b_q;
    ta_d = ta_q;  tb_d = tb_q;  ma_d = ma_q;  mb_d = mb_q;
    res_st_d = res_st_q;  res_same_d = res_same_q;
    count_d = cfg_we_i ? cfg_wdata_i : count_q;
    merge_d = merge_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ost_d = ost_q;  osame_d = osame_q;  osize_d = osize_q;
    osum_d = osum_q;  ocnt_d = ocnt_q;
    root_done = 1'b0;
    root_none = 1'b0;
    na = 1'b0;  nb = 1'b0;  rga = g_q;  rgb = g_q;

    case (state_q)
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(MAX_ELEMENTS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d      = s_axis_tdata[1:0];
          a_d        = s_axis_tdata[11:2];
          b_d        = s_axis_tdata[21:12];
          side_d     = 1'b0;
          res_st_d   = dsm_pkg::StOk;
          res_same_d = 1'b0;
          state_d    = S_E_RD;
        end
      end
      S_E_RD: begin
        if (!elem_ok) begin
          root_done = 1'b1;
          root_none = 1'b1;
        end else begin
          state_d = S_E_CAP;
        end
      end
      S_E_CAP: begin
        if (32'(eg_rdata) >= MAX_ELEMENTS) begin
          root_done = 1'b1;
          root_none = 1'b1;
        end else begin
          g_d     = eg_rdata;
          steps_d = '0;
          state_d = S_P_RD;
        end
      end
      S_P_RD: state_d = S_P_CAP;
      S_P_CAP: begin
        if (gp_rdata == g_q || 32'(gp_rdata) >= MAX_ELEMENTS) begin
          state_d = S_E_WR;
        end else begin
          g_d     = gp_rdata;
          steps_d = steps_q + 1'b1;
          // walk is capped at MAX_ELEMENTS links
          state_d = (32'(steps_q) + 1 == MAX_ELEMENTS) ? S_E_WR : S_P_RD;
        end
      end
      S_E_WR: root_done = 1'b1;
      S_A_RD: state_d = S_B_RD;
      S_B_RD: begin
        ta_d = tot_rdata;
        ma_d = mem_rdata;
        state_d = (cmd_q == dsm_pkg::CmdQuery) ? S_OUT : S_B_CAP;
      end
      S_B_CAP: begin
        tb_d = tot_rdata;
        mb_d = mem_rdata;
        state_d = S_WA_T;
      end
      S_WA_T: state_d = S_WA_M;
      S_WA_M: state_d = S_WB_T;
      S_WB_T: state_d = S_WB_M;
      S_WB_M: begin
        if (is_merge) merge_d = merge_q + 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          ost_d    = res_st_q;
          osame_d  = res_same_q;
          osize_d  = '0;
          osum_d   = '0;
          if (cmd_q == dsm_pkg::CmdQuery && res_st_q == dsm_pkg::StOk) begin
            osize_d = ma_q;
            osum_d  = ta_q[SumW-1:0];
          end
          ocnt_d  = (count_q >= merge_q) ? (count_q - merge_q) : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // one find finished: record it, then start the second or dispatch
    if (root_done) begin
      if (side_q) begin
        gb_d = g_q;  none_b_d = root_none;
        na = none_a_q;  rga = ga_q;
      end else begin
        ga_d = g_q;  none_a_d = root_none;
        na = root_none;  rga = g_q;
      end
      nb  = root_none;
      rgb = g_q;
      if (!side_q && cmd_q != dsm_pkg::CmdQuery) begin
        side_d  = 1'b1;
        state_d = S_E_RD;
      end else begin
        case (cmd_q)
          dsm_pkg::CmdMove, dsm_pkg::CmdMerge: begin
            if (na || nb) begin
              res_st_d = dsm_pkg::StRange;
              state_d  = S_OUT;
            end else if (rga == rgb) begin
              res_st_d = dsm_pkg::StSame;
              state_d  = S_OUT;
            end else begin
              state_d = S_A_RD;
            end
          end
          dsm_pkg::CmdSame: begin
            res_st_d   = (na || nb) ? dsm_pkg::StRange : dsm_pkg::StOk;
            res_same_d = (na && nb) || (!na && !nb && rga == rgb);
            state_d    = S_OUT;
          end
          default: begin
            if (na) begin
              res_st_d = dsm_pkg::StRange;
              state_d  = S_OUT;
            end else begin
              state_d = S_A_RD;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      count_q  <= CntW'(1023);
      merge_q  <= '0;
      ovalid_q <= 1'b0;
      side_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      count_q  <= count_d;
      merge_q  <= merge_d;
      ovalid_q <= ovalid_d;
      side_q   <= side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  a_q <= a_d;  b_q <= b_d;
    g_q <= g_d;  ga_q <= ga_d;  gb_q <= gb_d;  steps_q <= steps_d;
    none_a_q <= none_a_d;  none_b_q <= none_b_d;
    ta_q <= ta_d;  tb_q <= tb_d;  ma_q <= ma_d;  mb_q <= mb_d;
    res_st_q <= res_st_d;  res_same_q <= res_same_d;
    ost_q <= ost_d;  osame_q <= osame_d;  osize_q <= osize_d;
    osum_q <= osum_d;  ocnt_q <= ocnt_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'b0, ocnt_q, osum_q, osize_q, osame_q, ost_q};

`include "assert_macros.svh"

  // a command keeps the block busy in the cycle after it is taken
  `ASSERT_NXT(busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // no command is taken while the stores are being cleared
  `ASSERT_IMP(no_accept_in_clear, state_q == S_CLR, !s_axis_tready)
  // status code three is never produced
  `ASSERT_IMP(status_legal, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  // size and sum are only reported for a successful query; checked here on the size field
  `ASSERT_IMP(query_only_fields, m_axis_tvalid && m_axis_tdata[1:0] != dsm_pkg::StOk,
              m_axis_tdata[13:3] == '0)

endmodule

/* tb/dsm_checker.sv */
module dsm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [23:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [47:0] m_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NoGroup = -1;

  logic [9:0]  elem_count;
  logic [9:0]  elem_grp [1024];
  logic [9:0]  grp_link [1024];
  logic [19:0] grp_sum [1024];
  logic [10:0] grp_size [1024];
  logic [9:0]  merges;
  logic [42:0] expected_q[$];

  function automatic bit valid_idx(logic [9:0] i);
    return i <= elem_count;
  endfunction

  // walk to the root group and repoint the element at it
  function automatic int find_root(logic [9:0] e);
    int g;
    if (!valid_idx(e)) return NoGroup;
    g = elem_grp[e];
    for (int s = 0; s < 1024; s++) begin
      if (grp_link[g] == g) break;
      g = grp_link[g];
    end
    elem_grp[e] = 10'(g);
    return g;
  endfunction

  function automatic logic [42:0] apply_command(logic [23:0] w);
    logic [1:0]  cmd;
    logic [9:0]  a, b;
    logic [1:0]  st;
    logic        same;
    logic [10:0] sz;
    logic [18:0] sm;
    int ga, gb, big, sml;
    cmd = w[1:0]; a = w[11:2]; b = w[21:12];
    st = dsm_pkg::StOk; same = 1'b0; sz = '0; sm = '0;
    if (cmd == dsm_pkg::CmdMove || cmd == dsm_pkg::CmdMerge) begin
      ga = find_root(a);
      gb = find_root(b);
      if (ga == NoGroup || gb == NoGroup) st = dsm_pkg::StRange;
      else if (ga == gb) st = dsm_pkg::StSame;
      else if (cmd == dsm_pkg::CmdMove) begin
        grp_sum[ga] = grp_sum[ga] - {10'd0, a};
        grp_sum[gb] = grp_sum[gb] + {10'd0, a};
        grp_size[ga] = grp_size[ga] - 11'd1;
        grp_size[gb] = grp_size[gb] + 11'd1;
        elem_grp[a] = 10'(gb);
      end else begin
        big = gb; sml = ga;
        if (grp_size[ga] > grp_size[gb]) begin big = ga; sml = gb; end
        grp_sum[big] = grp_sum[big] + grp_sum[sml];
        grp_sum[sml] = '0;
        grp_size[big] = grp_size[big] + grp_size[sml];
        grp_size[sml] = '0;
        grp_link[sml] = 10'(big);
        merges = merges + 10'd1;
      end
    end else if (cmd == dsm_pkg::CmdSame) begin
      ga = find_root(a);
      gb = find_root(b);
      st = (ga == NoGroup || gb == NoGroup) ? dsm_pkg::StRange : dsm_pkg::StOk;
      same = (ga == gb);
    end else begin
      ga = find_root(a);
      if (ga == NoGroup) st = dsm_pkg::StRange;
      else begin
        sz = grp_size[ga];
        sm = grp_sum[ga][18:0];
      end
    end
    return {(elem_count >= merges) ? elem_count - merges : 10'd0, sm, sz, same, st};
  endfunction

  task automatic report(string what, logic [47:0] got, logic [42:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [42:0] want;
    if (!rst_ni) begin
      elem_count = 10'd1023;
      merges = '0;
      for (int i = 0; i < 1024; i++) begin
        elem_grp[i] = 10'(i); grp_link[i] = 10'(i); grp_sum[i] = 20'(i); grp_size[i] = 11'd1;
      end
      expected_q.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      // result side first: its expectation was queued on an earlier edge
      if (m_valid_i && m_ready_i) begin
        results_o++;
        if (expected_q.size() == 0) report("unexpected word", m_data_i, '0);
        else begin
          want = expected_q.pop_front();
          if (m_data_i[1:0] !== want[1:0]) report("status", m_data_i, want);
          if (m_data_i[2] !== want[2]) report("same_set", m_data_i, want);
          if (m_data_i[13:3] !== want[13:3]) report("group_size", m_data_i, want);
          if (m_data_i[32:14] !== want[32:14]) report("group_sum", m_data_i, want);
          if (m_data_i[42:33] !== want[42:33]) report("group_count", m_data_i, want);
          if (m_data_i[47:43] !== 5'd0) report("pad bits", m_data_i, want);
        end
      end
      if (cfg_we_i) elem_count = cfg_wdata_i;
      if (s_valid_i && s_ready_i) expected_q.push_back(apply_command(s_data_i));
    end
    pending_o = expected_q.size();
  end
endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [9:0]  cfg_wdata;
  logic        cmd_valid;
  logic        cmd_ready;
  logic [23:0] cmd_word;    // cmd[1:0] elem_a[11:2] elem_b[21:12] zero[23:22]
  logic        res_valid;
  logic        res_ready;
  logic [47:0] res_word;    // status[1:0] same_set[2] group_size[13:3] group_sum[32:14]
                            // group_count[42:33] zero[47:43]
  int          errors, pending, results;
  int          sent;
  logic [9:0]  limit_now;   // element_count currently programmed

  disjoint_set_with_move_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(cmd_valid), .s_axis_tready(cmd_ready), .s_axis_tdata(cmd_word),
    .m_axis_tvalid(res_valid), .m_axis_tready(res_ready), .m_axis_tdata(res_word)
  );

  // watches both channels and the register port, keeps the shadow state
  dsm_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .s_valid_i(cmd_valid), .s_ready_i(cmd_ready), .s_data_i(cmd_word),
    .m_valid_i(res_valid), .m_ready_i(res_ready), .m_data_i(res_word),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // one word per call; random gap before it, waits for the handshake
  task automatic send_cmd(logic [1:0] c, logic [9:0] a, logic [9:0] b);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= {2'b00, b, a, c};
    @(posedge clk_i);
    while (!cmd_ready) @(posedge clk_i);
    sent++;
  endtask

  // register write only once the block is drained
  task automatic set_count(logic [9:0] v);
    cmd_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    limit_now = v;
  endtask

  // index mostly in range, sometimes just past the limit or anywhere
  function automatic logic [9:0] pick_idx();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 10'($urandom_range(0, 1023));
    if (r == 1 && limit_now != 10'd1023) return limit_now + 10'd1;
    if (r == 2) return limit_now;
    return 10'($urandom_range(0, limit_now));
  endfunction

  task automatic random_phase(int n);
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      c = 2'($urandom_range(0, 3));
      send_cmd(c, pick_idx(), pick_idx());
    end
  endtask

  // result side: random stall before each word, with calm stretches
  initial begin
    int stall;
    res_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 7) < 2) ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ready <= 1'b1;
      @(posedge clk_i);
      while (!res_valid) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_valid = 1'b0;
    cmd_word = '0;
    sent = 0;
    limit_now = 10'd1023;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every command, range and same-group cases
    send_cmd(dsm_pkg::CmdQuery, 10'd1023, 10'd0);
    send_cmd(dsm_pkg::CmdQuery, 10'd0, 10'd1023);
    send_cmd(dsm_pkg::CmdSame,  10'd0, 10'd1023);
    send_cmd(dsm_pkg::CmdMerge, 10'd0, 10'd1023);
    send_cmd(dsm_pkg::CmdMerge, 10'd1023, 10'd0);
    send_cmd(dsm_pkg::CmdMove,  10'd1023, 10'd5);
    send_cmd(dsm_pkg::CmdMove,  10'd5, 10'd5);
    send_cmd(dsm_pkg::CmdQuery, 10'd5, 10'd0);
    send_cmd(dsm_pkg::CmdQuery, 10'd0, 10'd0);
    send_cmd(dsm_pkg::CmdMerge, 10'd1, 10'd2);
    send_cmd(dsm_pkg::CmdMerge, 10'd3, 10'd1);
    send_cmd(dsm_pkg::CmdMove,  10'd2, 10'd0);
    send_cmd(dsm_pkg::CmdSame,  10'd682, 10'd341);
    send_cmd(dsm_pkg::CmdQuery, 10'd1, 10'd682);
    set_count(10'd3);
    send_cmd(dsm_pkg::CmdSame,  10'd700, 10'd900);   // both out of range
    send_cmd(dsm_pkg::CmdSame,  10'd1, 10'd900);     // one out of range
    send_cmd(dsm_pkg::CmdMerge, 10'd1, 10'd4);
    send_cmd(dsm_pkg::CmdMove,  10'd4, 10'd1);
    send_cmd(dsm_pkg::CmdQuery, 10'd4, 10'd1);
    send_cmd(dsm_pkg::CmdQuery, 10'd3, 10'd0);
    set_count(10'd0);                                // count goes below merges
    send_cmd(dsm_pkg::CmdQuery, 10'd0, 10'd0);
    send_cmd(dsm_pkg::CmdSame,  10'd0, 10'd0);
    send_cmd(dsm_pkg::CmdMerge, 10'd0, 10'd1);

    // random phases over several limits, small sets merge deep
    set_count(10'd15);   random_phase(300);
    set_count(10'd63);   random_phase(300);
    set_count(10'd1023); random_phase(350);
    set_count(10'd200);  random_phase(300);
    set_count(10'd1);    random_phase(100);
    set_count(10'd511);  random_phase(200);

    cmd_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("sent %0d commands, checked %0d result words, limits from 0 to 1023",
             sent, results);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // well above a run where every command walks the longest chains under full stalls
  initial begin
    #300ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
